>>> rtl/core/arcsr_pkg.sv
package arcsr_pkg;

	// Fixed widths of the stored graph and of the arithmetic.
	localparam int OFFSET_W  = 14;
	localparam int COL_W     = 16;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int RECIP_W   = 17;
	localparam int RECIP_NUM = 65536;

	typedef enum logic [1:0] {
		OP_LOAD_OFFSET = 2'd0,
		OP_LOAD_COLUMN = 2'd1,
		OP_RUN         = 2'd2,
		OP_READ        = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT    = 3'd0,
		CFG_ITERATION_LIMIT = 3'd1,
		CFG_TOLERANCE       = 3'd2,
		CFG_DAMPING         = 3'd3,
		CFG_BASE_TERM       = 3'd4
	} cfg_index_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [12:0]        index;
		logic signed [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] contribution;
		logic [7:0]         iterations;
		logic               converged;
		logic               is_run_report;
	} out_item_t;

	typedef struct packed {
		logic [10:0]        vertex_count;
		logic [7:0]         iteration_limit;
		logic [31:0]        tolerance;
		logic [7:0]         damping;
		logic signed [31:0] base_term;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} eng_status_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_READ,
		S_DEG_A, S_DEG_B, S_AVG_S, S_AVG_W,
		S_ITER, S_SC,
		S_SP_A, S_SP_B, S_SP_C, S_SP_COL, S_SP_SRD, S_SP_SWR,
		S_UP_A, S_UP_B, S_UP_C, S_UP_D, S_UP_M, S_UP_W,
		S_ITER_END, S_RES
	} eng_state_t;

endpackage

>>> rtl/core/arcsr_div.sv
module arcsr_div
	import arcsr_pkg::*;
#(
	parameter int DW = 43
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DW-1:0]     quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]     num_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_nx;
	logic              fits;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		rem_sh = {rem_q, num_q[DW-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in where the dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			num_q <= {num_q[DW-2:0], fits};
			rem_q <= rem_nx[DATA_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

>>> rtl/core/arcsr_engine.sv
module arcsr_engine
	import arcsr_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cmd_valid,
	input  in_item_t    cmd,
	input  logic        out_free,
	output eng_status_t status,
	output out_item_t   res
);

	localparam int VAW   = $clog2(MAX_VERTICES);
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int CAW   = $clog2(MAX_EDGES);
	localparam int EW    = $clog2(MAX_EDGES + 1);
	localparam int TOT_W = DATA_W + NW;
	localparam logic [31:0] MAXV32 = 32'(MAX_VERTICES);
	localparam logic [31:0] MAXE32 = 32'(MAX_EDGES);

	// Graph and rank memories with registered reads.
	logic [OFFSET_W-1:0] off_mem     [MAX_VERTICES+1];
	logic [COL_W-1:0]    col_mem     [MAX_EDGES];
	logic [DATA_W-1:0]   contrib_mem [MAX_VERTICES];
	logic [DATA_W-1:0]   sum_mem     [MAX_VERTICES];

	logic                off_we, col_we, contrib_we, sum_we;
	logic [NW-1:0]       off_wa, off_ra;
	logic [CAW-1:0]      col_wa, col_ra;
	logic [VAW-1:0]      contrib_wa, contrib_ra, sum_wa, sum_ra;
	logic [OFFSET_W-1:0] off_wd, off_rd;
	logic [COL_W-1:0]    col_wd, col_rd;
	logic [DATA_W-1:0]   contrib_wd, contrib_rd, sum_wd, sum_rd;

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_wa] <= off_wd;
		end
		off_rd <= off_mem[off_ra];
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_wa] <= col_wd;
		end
		col_rd <= col_mem[col_ra];
	end

	always_ff @(posedge clk) begin
		if (contrib_we) begin
			contrib_mem[contrib_wa] <= contrib_wd;
		end
		contrib_rd <= contrib_mem[contrib_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		sum_rd <= sum_mem[sum_ra];
	end

	eng_state_t          state_q, state_d;
	logic [NW-1:0]       u_q;
	logic [EW-1:0]       e_q, hi_q;
	logic [OFFSET_W-1:0] lo_q, prev_q;
	logic [VAW-1:0]      col_q;
	logic [DATA_W-1:0]   cur_q, sum_q, avg_q, score_q, nc_q, max_q;
	logic [TOT_W-1:0]    total_q;
	logic [RECIP_W-1:0]  recip_q;
	logic [7:0]          it_q;
	logic                run_clr_q, rd_hit_q;
	out_item_t           res_q;

	// Shared divider for the average degree and the reciprocal.
	logic              div_start, div_done;
	logic [TOT_W-1:0]  div_num, div_quot;
	logic [DATA_W-1:0] div_den;

	arcsr_div #(.DW(TOT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Derived values used by the sequencer.
	logic [31:0]   n32, idx32, off_rd32, lo32, hi_cap32, col32, denom, score_w;
	logic [NW-1:0] n_w, u_inc;
	logic          u_last, clr_last, col_ok, e_done, rd_hit, has_edges;
	logic [EW-1:0] e_nx;
	logic [32:0]   d33, ad33;
	logic [7:0]    it_nx;

	always_comb begin
		n32       = (32'(cfg.vertex_count) > MAXV32) ? MAXV32 : 32'(cfg.vertex_count);
		n_w       = n32[NW-1:0];
		idx32     = 32'(cmd.index);
		off_rd32  = 32'(off_rd);
		lo32      = 32'(lo_q);
		hi_cap32  = (off_rd32 > MAXE32) ? MAXE32 : off_rd32;
		has_edges = lo32 < hi_cap32;
		col32     = 32'(col_rd);
		col_ok    = !col_rd[COL_W-1] && (col32 < n32);
		u_inc     = u_q + 1'b1;
		u_last    = (u_inc == n_w);
		clr_last  = (u_q == NW'(MAX_VERTICES - 1));
		e_nx      = e_q + 1'b1;
		e_done    = (e_nx == hi_q);
		rd_hit    = idx32 < n32;
		denom     = off_rd32 - lo32 + avg_q;
		score_w   = 32'({24'd0, cfg.damping} * sum_q) + $unsigned(cfg.base_term);
		d33       = {nc_q[DATA_W-1], nc_q} - {cur_q[DATA_W-1], cur_q};
		ad33      = d33[32] ? (33'd0 - d33) : d33;
		it_nx     = it_q + 1'b1;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d    = state_q;
		off_we     = 1'b0;
		off_wa     = idx32[NW-1:0];
		off_wd     = cmd.value[OFFSET_W-1:0];
		off_ra     = u_q;
		col_we     = 1'b0;
		col_wa     = idx32[CAW-1:0];
		col_wd     = cmd.value;
		col_ra     = e_q[CAW-1:0];
		contrib_we = 1'b0;
		contrib_wa = u_q[VAW-1:0];
		contrib_wd = '0;
		contrib_ra = u_q[VAW-1:0];
		sum_we     = 1'b0;
		sum_wa     = u_q[VAW-1:0];
		sum_wd     = '0;
		sum_ra     = u_q[VAW-1:0];
		div_start  = 1'b0;
		div_num    = total_q;
		div_den    = n32;
		status     = '{busy: 1'b1, res_valid: 1'b0};

		unique case (state_q)
			S_CLR: begin
				contrib_we = 1'b1;
				if (clr_last) begin
					state_d = run_clr_q ? S_DEG_A : S_IDLE;
				end
			end
			S_IDLE: begin
				status.busy = 1'b0;
				contrib_ra  = idx32[VAW-1:0];
				if (cmd_valid) begin
					unique case (cmd.opcode)
						OP_LOAD_OFFSET: off_we = (idx32 <= MAXV32);
						OP_LOAD_COLUMN: col_we = (idx32 < MAXE32);
						OP_RUN:         state_d = S_CLR;
						OP_READ:        state_d = S_READ;
						default:        state_d = S_IDLE;
					endcase
				end
			end
			S_READ: state_d = S_RES;
			S_DEG_A: state_d = S_DEG_B;
			S_DEG_B: state_d = (u_q == n_w) ? S_AVG_S : S_DEG_A;
			S_AVG_S: begin
				if (n_w == '0) begin
					state_d = S_ITER;
				end else begin
					div_start = 1'b1;
					state_d   = S_AVG_W;
				end
			end
			S_AVG_W: if (div_done) state_d = S_ITER;
			S_ITER: begin
				if (it_q == cfg.iteration_limit) begin
					state_d = S_RES;
				end else if (n_w == '0) begin
					state_d = S_ITER_END;
				end else begin
					state_d = S_SC;
				end
			end
			S_SC: begin
				sum_we = 1'b1;
				if (u_last) state_d = S_SP_A;
			end
			S_SP_A: state_d = S_SP_B;
			S_SP_B: begin
				off_ra  = u_inc;
				state_d = S_SP_C;
			end
			S_SP_C: begin
				if (has_edges) begin
					state_d = S_SP_COL;
				end else begin
					state_d = u_last ? S_UP_A : S_SP_A;
				end
			end
			S_SP_COL: state_d = S_SP_SRD;
			S_SP_SRD: begin
				sum_ra = col32[VAW-1:0];
				if (col_ok) begin
					state_d = S_SP_SWR;
				end else if (e_done) begin
					state_d = u_last ? S_UP_A : S_SP_A;
				end else begin
					state_d = S_SP_COL;
				end
			end
			S_SP_SWR: begin
				sum_we = 1'b1;
				sum_wa = col_q;
				sum_wd = sum_rd + cur_q;
				if (e_done) begin
					state_d = u_last ? S_UP_A : S_SP_A;
				end else begin
					state_d = S_SP_COL;
				end
			end
			S_UP_A: state_d = S_UP_B;
			S_UP_B: begin
				off_ra  = u_inc;
				state_d = S_UP_C;
			end
			S_UP_C: begin
				div_num = TOT_W'(RECIP_NUM);
				div_den = denom;
				if (denom == '0) begin
					state_d = S_UP_W;
				end else begin
					div_start = 1'b1;
					state_d   = S_UP_D;
				end
			end
			S_UP_D: if (div_done) state_d = S_UP_M;
			S_UP_M: state_d = S_UP_W;
			S_UP_W: begin
				contrib_we = 1'b1;
				contrib_wd = nc_q;
				state_d    = u_last ? S_ITER_END : S_UP_A;
			end
			S_ITER_END: begin
				if (max_q <= cfg.tolerance || it_nx == cfg.iteration_limit) begin
					state_d = S_RES;
				end else begin
					state_d = S_ITER;
				end
			end
			S_RES: begin
				status.res_valid = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q       <= '0;
			run_clr_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					u_q <= clr_last ? '0 : u_inc;
				end
				S_IDLE: begin
					if (cmd_valid && cmd.opcode == OP_RUN) begin
						run_clr_q <= 1'b1;
						u_q       <= '0;
					end
				end
				S_DEG_B: begin
					if (u_q != n_w) u_q <= u_inc;
				end
				S_ITER: u_q <= '0;
				S_SC: u_q <= u_last ? '0 : u_inc;
				S_SP_C: begin
					if (!has_edges) u_q <= u_last ? '0 : u_inc;
				end
				S_SP_SRD: begin
					if (!col_ok && e_done) u_q <= u_last ? '0 : u_inc;
				end
				S_SP_SWR: begin
					if (e_done) u_q <= u_last ? '0 : u_inc;
				end
				S_UP_W: u_q <= u_last ? '0 : u_inc;
				S_RES: run_clr_q <= 1'b0;
				default: u_q <= u_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_CLR: total_q <= '0;
			S_IDLE: rd_hit_q <= rd_hit;
			S_READ: begin
				res_q <= '{contribution: rd_hit_q ? contrib_rd : '0,
					iterations: 8'd0, converged: 1'b0, is_run_report: 1'b0};
			end
			S_DEG_B: begin
				if (u_q != '0) begin
					total_q <= total_q + TOT_W'(off_rd32 - 32'(prev_q));
				end
				prev_q <= off_rd;
			end
			S_AVG_S: begin
				avg_q <= '0;
				it_q  <= '0;
			end
			S_AVG_W: if (div_done) avg_q <= div_quot[DATA_W-1:0];
			S_ITER: begin
				max_q <= '0;
				res_q <= '{contribution: '0, iterations: it_q,
					converged: 1'b0, is_run_report: 1'b1};
			end
			S_SP_B: begin
				lo_q  <= off_rd;
				cur_q <= contrib_rd;
			end
			S_SP_C: begin
				hi_q <= hi_cap32[EW-1:0];
				e_q  <= lo32[EW-1:0];
			end
			S_SP_SRD: begin
				col_q <= col32[VAW-1:0];
				if (!col_ok) e_q <= e_nx;
			end
			S_SP_SWR: e_q <= e_nx;
			S_UP_B: begin
				lo_q  <= off_rd;
				cur_q <= contrib_rd;
				sum_q <= sum_rd;
			end
			S_UP_C: begin
				score_q <= score_w;
				if (denom == '0) nc_q <= '0;
			end
			S_UP_D: if (div_done) recip_q <= div_quot[RECIP_W-1:0];
			S_UP_M: nc_q <= score_q * 32'(recip_q);
			S_UP_W: begin
				if (ad33[31:0] > max_q) max_q <= ad33[31:0];
			end
			S_ITER_END: begin
				it_q  <= it_nx;
				res_q <= '{contribution: '0, iterations: it_nx,
					converged: (max_q <= cfg.tolerance), is_run_report: 1'b1};
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign res = res_q;

endmodule

>>> rtl/core/fixed_point_article_rank_csr.sv
// Fixed-point ArticleRank engine over a graph in compressed sparse row form.
// Input channel (in_valid, in_stall, in_data) carries one transaction per item:
// load offset, load column, run, or read contribution. Output channel
// (out_valid, out_stall, out_data) returns one transaction for each run and
// each read; loads return nothing. Registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the engine is
// idle, which the block itself does not enforce. Loads are accepted back to
// back. A read passes through the S_READ and S_RES states before its result
// is registered at the output. A run first clears the contribution memory,
// scans the offsets and divides for the average degree; each iteration then
// clears the sums, spreads each vertex's contribution along its edges, and
// updates each vertex, with the serial divider forming the reciprocal. All
// graph and rank state sits in memories with one write and one read port.
// After reset the contribution memory is swept to zero, during which in_stall
// is high. A result waits in the output register while out_stall is high;
// the engine holds the next result until that register frees and accepts no
// new transaction until then.
module fixed_point_article_rank_csr
	import arcsr_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 8192
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata
);

	cfg_t        cfg_q;
	eng_status_t status;
	out_item_t   res;
	out_item_t   out_q;
	logic        out_valid_q;
	logic        out_free;
	logic        cmd_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{vertex_count: 11'd0, iteration_limit: 8'd200, tolerance: 32'd1,
				damping: 8'd108, base_term: 32'sd1258291};
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_VERTEX_COUNT:    cfg_q.vertex_count    <= cfg_wdata[10:0];
				CFG_ITERATION_LIMIT: cfg_q.iteration_limit <= cfg_wdata[7:0];
				CFG_TOLERANCE:       cfg_q.tolerance       <= cfg_wdata;
				CFG_DAMPING:         cfg_q.damping         <= cfg_wdata[7:0];
				CFG_BASE_TERM:       cfg_q.base_term       <= cfg_wdata;
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_stall  = status.busy;
	assign cmd_valid = in_valid && !status.busy;
	assign out_free  = !out_valid_q || !out_stall;

	arcsr_engine #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (in_data),
		.out_free  (out_free),
		.status    (status),
		.res       (res)
	);

	// Output register between the engine and the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
